// ===== hw/rtl/par_pkg.sv =====
package par_pkg;

    // Default sizing
    localparam int MAX_CANDIDATES_DEF = 16;
    localparam int NUM_LOCALS_DEF     = 4;

    // Field widths
    localparam int ADDR_W       = 32;
    localparam int KIND_W       = 2;
    localparam int SCORE_W      = 3;
    localparam int ENTRY_W      = 38;
    localparam int PREFIX_W     = 6;
    localparam int LCOUNT_W     = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int OUT_TDATA_W  = 40;
    localparam int NUM_SCORES   = 8;

    // Input kind codes
    localparam logic [KIND_W-1:0] KIND_IPV4  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;

    // Score codes
    localparam logic [SCORE_W-1:0] SCORE_SUBNET   = 3'd0;
    localparam logic [SCORE_W-1:0] SCORE_PRIVATE  = 3'd1;
    localparam logic [SCORE_W-1:0] SCORE_LINK     = 3'd2;
    localparam logic [SCORE_W-1:0] SCORE_OTHER    = 3'd3;
    localparam logic [SCORE_W-1:0] SCORE_LOOPBACK = 3'd5;
    localparam logic [SCORE_W-1:0] SCORE_INVALID  = 3'd6;

    // Register indexes (0..3 are the local entries)
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_COUNT = 3'd4;

    // Address class prefixes
    localparam logic [7:0]  NET_LOOPBACK = 8'd127;
    localparam logic [7:0]  NET_TEN      = 8'd10;
    localparam logic [11:0] NET_172_16   = 12'hac1;
    localparam logic [15:0] NET_192_168  = 16'hc0a8;
    localparam logic [9:0]  NET_100_64   = 10'h191;
    localparam logic [15:0] NET_LINK     = 16'ha9fe;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PASS,
        ST_READ,
        ST_TEST
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic commit;
        logic scan_init;
        logic pass_start;
        logic pass_next;
        logic rd_issue;
        logic emit;
        logic idx_next;
        logic finish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic item_last;
        logic scan_done;
        logic pass_present;
        logic rd_match;
        logic idx_end;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/par_ctrl.sv =====
module par_ctrl
    import par_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  status_t status,
    output logic    in_ready,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                // datapath latches the word on the handshake itself
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.commit = 1'b1;
                if (status.item_last)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_PASS;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PASS:
            begin
                if (status.scan_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.pass_present)
                begin
                    cmd.pass_start = 1'b1;
                    state_next     = ST_READ;
                end
                else
                begin
                    cmd.pass_next = 1'b1;
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_TEST;
            end
            ST_TEST:
            begin
                // hold on a matching entry until the output register frees up
                if (!status.rd_match || status.out_free)
                begin
                    cmd.emit = status.rd_match;
                    if (status.idx_end)
                    begin
                        cmd.pass_next = 1'b1;
                        state_next    = ST_PASS;
                    end
                    else
                    begin
                        cmd.idx_next = 1'b1;
                        state_next   = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/par_datapath.sv =====
module par_datapath
    import par_pkg::*;
#(
    parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF,
    parameter int NUM_LOCALS     = NUM_LOCALS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input word
    input  logic                   in_load,
    input  logic [ADDR_W-1:0]      in_address,
    input  logic [KIND_W-1:0]      in_kind,
    input  logic                   in_last,
    // configuration
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [ENTRY_W-1:0]     cfg_data,
    // control
    input  cmd_t                   cmd,
    output status_t                status,
    // result word
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [ADDR_W-1:0]      out_address,
    output logic                   out_kind,
    output logic [SCORE_W-1:0]     out_score,
    output logic                   out_overflowed,
    output logic                   out_last
);

    localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
    localparam int IDX_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int MEM_W = SCORE_W + 1 + ADDR_W;

    // Configuration registers
    logic [ENTRY_W-1:0]  local_entry_reg [NUM_LOCALS];
    logic [LCOUNT_W-1:0] local_count_reg;

    // Item under check
    logic [ADDR_W-1:0]         item_addr_reg;
    logic                      item_nk_reg;
    logic                      item_keep_reg;
    logic                      item_last_reg;
    logic [SCORE_W-1:0]        item_score_reg;
    logic [MAX_CANDIDATES-1:0] match_reg;

    // Kept list: compare copy in flops, ranked copy in memory
    logic [ADDR_W-1:0]  cam_addr_reg [MAX_CANDIDATES];
    logic               cam_kind_reg [MAX_CANDIDATES];
    logic [MEM_W-1:0]   kept_mem [MAX_CANDIDATES];
    logic [CNT_W-1:0]   count_reg;
    logic               overflow_reg;
    logic [NUM_SCORES-1:0] present_reg;

    // Scan state
    logic [SCORE_W-1:0] pass_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   emitted_reg;
    logic [MEM_W-1:0]   rd_reg;

    // Output register
    logic               out_valid_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic               out_kind_reg;
    logic [SCORE_W-1:0] out_score_reg;
    logic               out_ovf_reg;
    logic               out_last_reg;

    logic               in_nk;
    logic               subnet_hit;
    logic [SCORE_W-1:0] score_calc;
    logic [MAX_CANDIDATES-1:0] match_calc;
    logic               dup;
    logic               room;
    logic               rd_kind;
    logic [SCORE_W-1:0] rd_score;
    logic [ADDR_W-1:0]  rd_addr;

    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] p);
        logic [ADDR_W-1:0] m;
        if (p == '0 || p >= PREFIX_W'(ADDR_W))
        begin
            m = '1;
        end
        else
        begin
            m = ~({ADDR_W{1'b1}} >> p);
        end
        return m;
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_LOCALS; j++)
            begin
                local_entry_reg[j] <= '0;
            end
            local_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            for (int j = 0; j < NUM_LOCALS; j++)
            begin
                if (cfg_index == CFG_IDX_W'(j))
                begin
                    local_entry_reg[j] <= cfg_data;
                end
            end
            if (cfg_index == CFG_LOCAL_COUNT)
            begin
                local_count_reg <= cfg_data[LCOUNT_W-1:0];
            end
        end
    end

    // Subnet match against active local entries
    always_comb
    begin
        subnet_hit = 1'b0;
        for (int j = 0; j < NUM_LOCALS; j++)
        begin
            if (LCOUNT_W'(j) < local_count_reg &&
                ((in_address ^ local_entry_reg[j][ENTRY_W-1:PREFIX_W]) &
                 prefix_mask(local_entry_reg[j][PREFIX_W-1:0])) == '0)
            begin
                subnet_hit = 1'b1;
            end
        end
    end

    // Score: non-IPv4 kind first, then loopback
    always_comb
    begin
        if (in_kind == KIND_OTHER)
            score_calc = SCORE_INVALID;
        else if (in_address[31:24] == NET_LOOPBACK)
            score_calc = SCORE_LOOPBACK;
        else if (subnet_hit)
            score_calc = SCORE_SUBNET;
        else if (in_address[31:24] == NET_TEN || in_address[31:20] == NET_172_16 ||
                 in_address[31:16] == NET_192_168 || in_address[31:22] == NET_100_64)
            score_calc = SCORE_PRIVATE;
        else if (in_address[31:16] == NET_LINK)
            score_calc = SCORE_LINK;
        else
            score_calc = SCORE_OTHER;
    end

    // Duplicate compare, one lane per kept entry
    assign in_nk = (in_kind == KIND_OTHER);
    always_comb
    begin
        for (int i = 0; i < MAX_CANDIDATES; i++)
        begin
            match_calc[i] = (CNT_W'(i) < count_reg) && (cam_addr_reg[i] == in_address) &&
                            (cam_kind_reg[i] == in_nk);
        end
    end

    // Latch the item on accept
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            item_addr_reg  <= in_address;
            item_nk_reg    <= in_nk;
            item_keep_reg  <= (in_kind == KIND_IPV4) || (in_kind == KIND_OTHER);
            item_last_reg  <= in_last;
            item_score_reg <= score_calc;
            match_reg      <= match_calc;
        end
    end

    assign dup  = |match_reg;
    assign room = count_reg < CNT_W'(MAX_CANDIDATES);

    // Kept list control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            present_reg  <= '0;
        end
        else if (cmd.finish)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            present_reg  <= '0;
        end
        else if (cmd.commit && item_keep_reg && !dup)
        begin
            if (room)
            begin
                count_reg                   <= count_reg + CNT_W'(1);
                present_reg[item_score_reg] <= 1'b1;
            end
            else
            begin
                overflow_reg <= 1'b1;
            end
        end
    end

    // Compare copy
    always_ff @(posedge clk)
    begin
        if (cmd.commit && item_keep_reg && !dup && room)
        begin
            cam_addr_reg[count_reg[IDX_W-1:0]] <= item_addr_reg;
            cam_kind_reg[count_reg[IDX_W-1:0]] <= item_nk_reg;
        end
    end

    // Ranked copy in memory
    always_ff @(posedge clk)
    begin
        if (cmd.commit && item_keep_reg && !dup && room)
        begin
            kept_mem[count_reg[IDX_W-1:0]] <= {item_score_reg, item_nk_reg, item_addr_reg};
        end
        if (cmd.rd_issue)
        begin
            rd_reg <= kept_mem[idx_reg];
        end
    end

    assign rd_score = rd_reg[MEM_W-1 -: SCORE_W];
    assign rd_kind  = rd_reg[ADDR_W];
    assign rd_addr  = rd_reg[ADDR_W-1:0];

    // Scan counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg    <= '0;
            idx_reg     <= '0;
            emitted_reg <= '0;
        end
        else
        begin
            if (cmd.scan_init)
            begin
                pass_reg    <= '0;
                emitted_reg <= '0;
            end
            if (cmd.pass_next)
                pass_reg <= pass_reg + SCORE_W'(1);
            if (cmd.pass_start)
                idx_reg <= '0;
            if (cmd.idx_next)
                idx_reg <= idx_reg + IDX_W'(1);
            if (cmd.emit)
                emitted_reg <= emitted_reg + CNT_W'(1);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_addr_reg  <= rd_addr;
            out_kind_reg  <= rd_kind;
            out_score_reg <= rd_score;
            out_ovf_reg   <= overflow_reg;
            out_last_reg  <= (emitted_reg + CNT_W'(1)) == count_reg;
        end
    end

    assign status.item_last    = item_last_reg;
    assign status.scan_done    = emitted_reg == count_reg;
    assign status.pass_present = present_reg[pass_reg];
    assign status.rd_match     = rd_score == pass_reg;
    assign status.idx_end      = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign status.out_free     = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign out_address    = out_addr_reg;
    assign out_kind       = out_kind_reg;
    assign out_score      = out_score_reg;
    assign out_overflowed = out_ovf_reg;
    assign out_last       = out_last_reg;

endmodule

// ===== hw/rtl/peer_address_ranker_core.sv =====
// Each candidate word is accepted, then duplicate-checked and stored; no new word is taken during the check.
// On the last word the kept list is replayed from memory once per score present;
// each score pass reads every kept entry in turn (memory read, then score test).
// Output stalls hold the scan.
// Reset (rst_n, async, active low) empties the list, clears config and control; no clear pass.
module peer_address_ranker_core
    import par_pkg::*;
#(
    parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF,
    parameter int NUM_LOCALS     = NUM_LOCALS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // candidate stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [ADDR_W-1:0]      s_axis_tdata,   // [31:0] address
    input  logic [KIND_W-1:0]      s_axis_tuser,   // [1:0] kind
    input  logic                   s_axis_tlast,
    // ranked stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] address, [34:32] score,
                                                   // [35] overflowed, [39:36] zero
    output logic [0:0]             m_axis_tuser,   // [0] ranked kind
    output logic                   m_axis_tlast,
    // register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [ENTRY_W-1:0]     cfg_data
);

    cmd_t               cmd;
    status_t            status;
    logic               in_ready;
    logic [ADDR_W-1:0]  out_address;
    logic               out_kind;
    logic [SCORE_W-1:0] out_score;
    logic               out_overflowed;

    assign s_axis_tready = in_ready;
    assign cfg_ready     = 1'b1;

    par_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    par_datapath #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .NUM_LOCALS     (NUM_LOCALS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_load        (s_axis_tvalid && in_ready),
        .in_address     (s_axis_tdata),
        .in_kind        (s_axis_tuser),
        .in_last        (s_axis_tlast),
        .cfg_write      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_address    (out_address),
        .out_kind       (out_kind),
        .out_score      (out_score),
        .out_overflowed (out_overflowed),
        .out_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, out_overflowed, out_score, out_address};
    assign m_axis_tuser = out_kind;

endmodule

// ===== hw/rtl/par_checker.sv =====
module par_checker
    import par_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic [0:0]             m_axis_tuser,
    input  logic                   m_axis_tlast
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // no word is taken while the previous one is under duplicate check
    a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("candidate accepted during duplicate check");

    // non-IPv4 entries always rank as invalid
    a_kind_score: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tdata[34:32] == SCORE_INVALID)))
        else $error("kind and score disagree");

    // only defined scores appear
    a_score_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
        (m_axis_tdata[34:32] == SCORE_SUBNET || m_axis_tdata[34:32] == SCORE_PRIVATE ||
         m_axis_tdata[34:32] == SCORE_LINK || m_axis_tdata[34:32] == SCORE_OTHER ||
         m_axis_tdata[34:32] == SCORE_LOOPBACK || m_axis_tdata[34:32] == SCORE_INVALID))
        else $error("undefined score code");

endmodule

bind peer_address_ranker_core par_checker u_par_checker (.*);
